// ===== hw/rtl/assert_macros.svh =====
// assert_macros.svh: concurrent assertion helpers for the sprite frame sequencer
// expects clk and arst_n in the module that includes it
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SFS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SFS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/sfs_pkg.sv =====
// sfs_pkg: shared types and constants of the sprite frame sequencer
// used by sfs_div, sfs_core and sprite_frame_sequencer_unit
package sfs_pkg;

	localparam int MAX_COLUMNS = 64;
	localparam int MAX_ROWS    = 64;
	localparam int TIME_BITS   = 16;
	localparam int ACC_W       = TIME_BITS + 1;
	localparam int FRAME_W     = 12;
	localparam int COUNT_W     = 13;
	localparam int DIM_W       = 7;
	localparam int CELL_W      = 6;
	localparam int DIV_DW      = 22;
	localparam int DIV_CNT_W   = $clog2(DIV_DW);
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	typedef enum logic [1:0] {
		OP_TICK,
		OP_PLAY,
		OP_STOP,
		OP_RESET
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_FRAME,
		CFG_FRAME_COUNT,
		CFG_FRAME_DURATION,
		CFG_LOOP_ENABLE,
		CFG_REVERSE,
		CFG_COLUMNS,
		CFG_ROWS
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STEP,
		ST_DIV_ROW,
		ST_DIV_U,
		ST_DIV_V,
		ST_DIV_US,
		ST_DIV_VS,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [FRAME_W-1:0]   start_frame;
		logic [COUNT_W-1:0]   frame_count;
		logic [TIME_BITS-1:0] frame_duration;
		logic                 loop_enable;
		logic                 reverse;
		logic [DIM_W-1:0]     cols_eff;
		logic [DIM_W-1:0]     rows_eff;
		logic [FRAME_W-1:0]   cap_m1;
	} cfg_t;

	typedef struct packed {
		logic              start;
		logic [DIV_DW-1:0] dividend;
		logic [DIM_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DIV_DW-1:0] quotient;
		logic [DIM_W-1:0]  remainder;
	} div_rsp_t;

	typedef struct packed {
		logic                 valid;
		logic [FRAME_W-1:0]   frame_index;
		logic [CELL_W-1:0]    cell_column;
		logic [CELL_W-1:0]    cell_row;
		logic [15:0]          u_offset;
		logic [15:0]          v_offset;
		logic [16:0]          u_scale;
		logic [16:0]          v_scale;
		logic                 is_playing;
		logic                 is_finished;
	} res_t;

endpackage

// ===== hw/rtl/sfs_div.sv =====
// sfs_div: shared restoring divider, one quotient bit per cycle
// depends on sfs_pkg and assert_macros.svh
`include "assert_macros.svh"

module sfs_div (
	input  logic              clk,
	input  logic              arst_n,
	input  sfs_pkg::div_req_t req,
	output sfs_pkg::div_rsp_t rsp
);

	logic                          busy_q;
	logic                          done_q;
	logic [sfs_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [sfs_pkg::DIV_DW-1:0]    dvd_q;
	logic [sfs_pkg::DIV_DW-1:0]    quo_q;
	logic [sfs_pkg::DIM_W-1:0]     rem_q;
	logic [sfs_pkg::DIM_W-1:0]     dvs_q;
	logic [sfs_pkg::DIM_W:0]       rem_sh;
	logic [sfs_pkg::DIM_W:0]       rem_sub;
	logic                          ge;

	assign rem_sh  = {rem_q, dvd_q[sfs_pkg::DIV_DW-1]};
	assign ge      = rem_sh >= {1'b0, dvs_q};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= sfs_pkg::DIV_CNT_W'(sfs_pkg::DIV_DW - 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			dvd_q <= {dvd_q[sfs_pkg::DIV_DW-2:0], 1'b0};
			quo_q <= {quo_q[sfs_pkg::DIV_DW-2:0], ge};
			rem_q <= ge ? rem_sub[sfs_pkg::DIM_W-1:0] : rem_sh[sfs_pkg::DIM_W-1:0];
		end else if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			quo_q <= '0;
			rem_q <= '0;
		end
	end

	assign rsp.busy      = busy_q;
	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

	`SFS_ASSERT_NEXT(a_div_done_after_last, busy_q && cnt_q == '0, done_q && !busy_q, "divider missed done")

endmodule

// ===== hw/rtl/sfs_core.sv =====
// sfs_core: sequencer holding play state, frame stepping loop and division schedule
// depends on sfs_pkg, assert_macros.svh; drives the shared sfs_div
`include "assert_macros.svh"

module sfs_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sfs_pkg::cfg_t                   cfg,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  sfs_pkg::op_t                    in_op,
	input  logic [sfs_pkg::TIME_BITS-1:0]   in_elapsed,
	input  logic                            in_restart,
	input  logic                            out_free,
	output sfs_pkg::res_t                   res,
	output sfs_pkg::div_req_t               div_req,
	input  sfs_pkg::div_rsp_t               div_rsp
);

	localparam int FW = sfs_pkg::FRAME_W;
	localparam int EW = sfs_pkg::FRAME_W + 2;
	localparam int AW = sfs_pkg::ACC_W;

	sfs_pkg::state_t state_q, state_d;

	logic [AW-1:0]               acc_q;
	logic [FW-1:0]               frame_q;
	logic                        playing_q;
	logic                        finished_q;
	logic                        started_q;
	logic                        issued_q;
	logic [sfs_pkg::CELL_W-1:0]  col_q;
	logic [sfs_pkg::CELL_W-1:0]  row_q;
	logic [15:0]                 uoff_q;
	logic [15:0]                 voff_q;
	logic [16:0]                 usc_q;
	logic [16:0]                 vsc_q;

	logic [sfs_pkg::COUNT_W-1:0] cnt_eff;
	logic [EW-1:0]               first;
	logic [EW-1:0]               clip_end;
	logic [EW-1:0]               end_m1;
	logic [EW-1:0]               rewind;
	logic [EW-1:0]               cur;
	logic [EW-1:0]               step_raw;
	logic                        step_fin;
	logic [AW:0]                 acc_sum;
	logic [AW-1:0]               acc_sat;
	logic [AW-1:0]               dur;
	logic                        dur_nz;
	logic                        acc_ge;
	logic                        in_acc;
	logic                        div_state;
	logic [FW-1:0]               fdisp;

	function automatic logic [FW-1:0] clamp_fn(input logic [EW-1:0] f, input logic [FW-1:0] lim);
		return (f > {2'b00, lim}) ? lim : f[FW-1:0];
	endfunction

	assign cnt_eff  = (cfg.frame_count == '0) ? sfs_pkg::COUNT_W'(1) : cfg.frame_count;
	assign first    = {2'b00, cfg.start_frame};
	assign clip_end = first + {1'b0, cnt_eff};
	assign end_m1   = clip_end - EW'(1);
	assign rewind   = cfg.reverse ? end_m1 : first;
	assign cur      = {2'b00, frame_q};
	assign fdisp    = clamp_fn(cur, cfg.cap_m1);

	assign dur     = {1'b0, cfg.frame_duration};
	assign dur_nz  = cfg.frame_duration != '0;
	assign acc_sum = {1'b0, acc_q} + {2'b00, in_elapsed};
	assign acc_sat = acc_sum[AW] ? '1 : acc_sum[AW-1:0];
	assign acc_ge  = acc_q >= dur;
	assign in_acc  = in_valid && in_ready;

	always_comb begin
		step_fin = 1'b0;
		if (cfg.reverse) begin
			if (cur <= first) begin
				step_raw = cfg.loop_enable ? end_m1 : first;
				step_fin = !cfg.loop_enable;
			end else begin
				step_raw = cur - EW'(1);
			end
		end else begin
			if (cur + EW'(1) >= clip_end) begin
				step_raw = cfg.loop_enable ? first : end_m1;
				step_fin = !cfg.loop_enable;
			end else begin
				step_raw = cur + EW'(1);
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sfs_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (in_op == sfs_pkg::OP_TICK && playing_q && dur_nz)
						state_d = sfs_pkg::ST_STEP;
					else
						state_d = sfs_pkg::ST_DIV_ROW;
				end
			end
			sfs_pkg::ST_STEP: begin
				if (!(acc_ge && playing_q))
					state_d = sfs_pkg::ST_DIV_ROW;
			end
			sfs_pkg::ST_DIV_ROW: if (div_rsp.done) state_d = sfs_pkg::ST_DIV_U;
			sfs_pkg::ST_DIV_U:   if (div_rsp.done) state_d = sfs_pkg::ST_DIV_V;
			sfs_pkg::ST_DIV_V:   if (div_rsp.done) state_d = sfs_pkg::ST_DIV_US;
			sfs_pkg::ST_DIV_US:  if (div_rsp.done) state_d = sfs_pkg::ST_DIV_VS;
			sfs_pkg::ST_DIV_VS:  if (div_rsp.done) state_d = sfs_pkg::ST_DONE;
			sfs_pkg::ST_DONE:    if (out_free) state_d = sfs_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready         = state_q == sfs_pkg::ST_IDLE;
		div_state        = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = cfg.cols_eff;
		unique case (state_q)
			sfs_pkg::ST_DIV_ROW: begin
				div_state        = 1'b1;
				div_req.dividend = sfs_pkg::DIV_DW'(fdisp);
			end
			sfs_pkg::ST_DIV_U: begin
				div_state        = 1'b1;
				div_req.dividend = sfs_pkg::DIV_DW'({col_q, 16'h0000});
			end
			sfs_pkg::ST_DIV_V: begin
				div_state        = 1'b1;
				div_req.dividend = sfs_pkg::DIV_DW'({row_q, 16'h0000});
				div_req.divisor  = cfg.rows_eff;
			end
			sfs_pkg::ST_DIV_US: begin
				div_state        = 1'b1;
				div_req.dividend = sfs_pkg::DIV_DW'(17'h10000);
			end
			sfs_pkg::ST_DIV_VS: begin
				div_state        = 1'b1;
				div_req.dividend = sfs_pkg::DIV_DW'(17'h10000);
				div_req.divisor  = cfg.rows_eff;
			end
			default: begin
				div_state = 1'b0;
			end
		endcase
		div_req.start = div_state && !issued_q && !div_rsp.done;

		res.valid       = (state_q == sfs_pkg::ST_DONE) && out_free;
		res.frame_index = fdisp;
		res.cell_column = col_q;
		res.cell_row    = row_q;
		res.u_offset    = uoff_q;
		res.v_offset    = voff_q;
		res.u_scale     = usc_q;
		res.v_scale     = vsc_q;
		res.is_playing  = playing_q;
		res.is_finished = finished_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= sfs_pkg::ST_IDLE;
			acc_q      <= '0;
			frame_q    <= '0;
			playing_q  <= 1'b0;
			finished_q <= 1'b0;
			started_q  <= 1'b0;
			issued_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (div_req.start)
				issued_q <= 1'b1;
			else if (div_rsp.done)
				issued_q <= 1'b0;

			if (in_acc) begin
				unique case (in_op)
					sfs_pkg::OP_TICK: begin
						if (playing_q && dur_nz)
							acc_q <= acc_sat;
					end
					sfs_pkg::OP_PLAY: begin
						if (!started_q || in_restart) begin
							started_q <= 1'b1;
							frame_q   <= clamp_fn(rewind, cfg.cap_m1);
							acc_q     <= '0;
						end
						playing_q  <= 1'b1;
						finished_q <= 1'b0;
					end
					sfs_pkg::OP_STOP: begin
						playing_q <= 1'b0;
					end
					sfs_pkg::OP_RESET: begin
						frame_q    <= started_q ? clamp_fn(rewind, cfg.cap_m1) : '0;
						acc_q      <= '0;
						playing_q  <= 1'b0;
						finished_q <= 1'b0;
					end
				endcase
			end else if (state_q == sfs_pkg::ST_STEP && acc_ge && playing_q) begin
				acc_q   <= acc_q - dur;
				frame_q <= clamp_fn(step_raw, cfg.cap_m1);
				if (step_fin) begin
					playing_q  <= 1'b0;
					finished_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_rsp.done) begin
			unique case (state_q)
				sfs_pkg::ST_DIV_ROW: begin
					row_q <= div_rsp.quotient[sfs_pkg::CELL_W-1:0];
					col_q <= div_rsp.remainder[sfs_pkg::CELL_W-1:0];
				end
				sfs_pkg::ST_DIV_U:  uoff_q <= div_rsp.quotient[15:0];
				sfs_pkg::ST_DIV_V:  voff_q <= div_rsp.quotient[15:0];
				sfs_pkg::ST_DIV_US: usc_q  <= div_rsp.quotient[16:0];
				sfs_pkg::ST_DIV_VS: vsc_q  <= div_rsp.quotient[16:0];
				default: ;
			endcase
		end
	end

	`SFS_ASSERT_IMPL(a_finished_not_playing, finished_q, !playing_q, "finished while playing")
	`SFS_ASSERT_NEXT(a_busy_after_transfer, in_acc, state_q != sfs_pkg::ST_IDLE, "idle after transfer")
	`SFS_ASSERT_IMPL(a_issue_when_free, div_req.start, !div_rsp.busy, "divider started while busy")

endmodule

// ===== hw/rtl/sprite_frame_sequencer_unit.sv =====
// sprite_frame_sequencer_unit: top level with config registers, sheet geometry and output register
// depends on sfs_pkg, sfs_div, sfs_core and assert_macros.svh
//
// channel  | direction | handshake            | payload
// s_*      | in        | s_tvalid / s_tready  | s_tuser op, s_tdata elapsed and restart
// m_*      | out       | m_tvalid / m_tready  | m_tdata frame, cell, uv offset and scale, flags
// cfg_*    | in        | cfg_we               | cfg_index, cfg_data
//
// every item runs the division schedule; a tick while playing first runs the step state
// the five divisions go through the shared one-bit-per-cycle divider
// the tick catch-up loop steps one frame per cycle
// arst_n clears state and loads config reset values; no clearing pass
// s_tready drops until the result sits in the output register, which may wait on m_tready
`include "assert_macros.svh"

module sprite_frame_sequencer_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [23:0]                       s_tdata,   // elapsed[15:0], restart[16], zero pad
	input  logic [1:0]                        s_tuser,   // operation[1:0]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// frame_index, cell_column, cell_row, u_offset, v_offset, u_scale, v_scale,
	// is_playing, is_finished, zero pad
	output logic [95:0]                       m_tdata,
	input  logic                              cfg_we,
	input  logic [sfs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sfs_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic [sfs_pkg::FRAME_W-1:0]   start_frame_q;
	logic [sfs_pkg::COUNT_W-1:0]   frame_count_q;
	logic [sfs_pkg::TIME_BITS-1:0] frame_duration_q;
	logic                          loop_enable_q;
	logic                          reverse_q;
	logic [sfs_pkg::DIM_W-1:0]     columns_q;
	logic [sfs_pkg::DIM_W-1:0]     rows_q;

	logic [sfs_pkg::DIM_W-1:0]     cols_eff;
	logic [sfs_pkg::DIM_W-1:0]     rows_eff;
	logic [2*sfs_pkg::DIM_W-1:0]   cap_prod;
	logic [2*sfs_pkg::DIM_W-1:0]   cap;

	sfs_pkg::cfg_t     cfg;
	sfs_pkg::res_t     res;
	sfs_pkg::div_req_t div_req;
	sfs_pkg::div_rsp_t div_rsp;

	logic        m_tvalid_q;
	logic [95:0] m_tdata_q;
	logic        out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_frame_q    <= '0;
			frame_count_q    <= sfs_pkg::COUNT_W'(1);
			frame_duration_q <= '0;
			loop_enable_q    <= 1'b0;
			reverse_q        <= 1'b0;
			columns_q        <= sfs_pkg::DIM_W'(1);
			rows_q           <= sfs_pkg::DIM_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				sfs_pkg::CFG_START_FRAME:    start_frame_q    <= cfg_data[sfs_pkg::FRAME_W-1:0];
				sfs_pkg::CFG_FRAME_COUNT:    frame_count_q    <= cfg_data[sfs_pkg::COUNT_W-1:0];
				sfs_pkg::CFG_FRAME_DURATION: frame_duration_q <= cfg_data[sfs_pkg::TIME_BITS-1:0];
				sfs_pkg::CFG_LOOP_ENABLE:    loop_enable_q    <= cfg_data[0];
				sfs_pkg::CFG_REVERSE:        reverse_q        <= cfg_data[0];
				sfs_pkg::CFG_COLUMNS:        columns_q        <= cfg_data[sfs_pkg::DIM_W-1:0];
				sfs_pkg::CFG_ROWS:           rows_q           <= cfg_data[sfs_pkg::DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// sheet geometry, clamped
	always_comb begin
		if (columns_q == '0)
			cols_eff = sfs_pkg::DIM_W'(1);
		else if (columns_q > sfs_pkg::DIM_W'(sfs_pkg::MAX_COLUMNS))
			cols_eff = sfs_pkg::DIM_W'(sfs_pkg::MAX_COLUMNS);
		else
			cols_eff = columns_q;

		if (rows_q == '0)
			rows_eff = sfs_pkg::DIM_W'(1);
		else if (rows_q > sfs_pkg::DIM_W'(sfs_pkg::MAX_ROWS))
			rows_eff = sfs_pkg::DIM_W'(sfs_pkg::MAX_ROWS);
		else
			rows_eff = rows_q;

		cap_prod = cols_eff * rows_eff;
		cap      = (cap_prod > (2*sfs_pkg::DIM_W)'(4096)) ? (2*sfs_pkg::DIM_W)'(4096) : cap_prod;
	end

	always_comb begin
		cfg.start_frame    = start_frame_q;
		cfg.frame_count    = frame_count_q;
		cfg.frame_duration = frame_duration_q;
		cfg.loop_enable    = loop_enable_q;
		cfg.reverse        = reverse_q;
		cfg.cols_eff       = cols_eff;
		cfg.rows_eff       = rows_eff;
		cfg.cap_m1         = sfs_pkg::FRAME_W'(cap - (2*sfs_pkg::DIM_W)'(1));
	end

	sfs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	sfs_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_op      (sfs_pkg::op_t'(s_tuser)),
		.in_elapsed (s_tdata[sfs_pkg::TIME_BITS-1:0]),
		.in_restart (s_tdata[16]),
		.out_free   (out_free),
		.res        (res),
		.div_req    (div_req),
		.div_rsp    (div_rsp)
	);

	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res.valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			m_tdata_q <= {4'h0, res.is_finished, res.is_playing, res.v_scale, res.u_scale,
				res.v_offset, res.u_offset, res.cell_row, res.cell_column, res.frame_index};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`SFS_ASSERT_IMPL(a_no_result_overwrite, res.valid, !m_tvalid_q || m_tready, "result overwritten")

endmodule

// ===== test/sprite_frame_sequencer_unit_tb.sv =====
// sprite_frame_sequencer_unit_tb: self-checking bench for the sprite frame sequencer
// drives play, stop, reset and tick transfers with random idling, predicts every result
// depends on sfs_pkg and sprite_frame_sequencer_unit
module sprite_frame_sequencer_unit_tb;

	localparam int unsigned ACC_LIMIT = (1 << sfs_pkg::ACC_W) - 1;
	localparam int RANDOM_PHASES = 10;
	localparam int ITEMS_PER_PHASE = 53;

	typedef struct packed {
		logic [sfs_pkg::FRAME_W-1:0] frame;
		logic [sfs_pkg::CELL_W-1:0]  col;
		logic [sfs_pkg::CELL_W-1:0]  row;
		logic [15:0]                 u_off;
		logic [15:0]                 v_off;
		logic [16:0]                 u_scl;
		logic [16:0]                 v_scl;
		logic                        playing;
		logic                        finished;
	} cell_view_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		sfs_pkg::cfg_idx_t sel;
		logic [15:0]       value;
		sfs_pkg::op_t      op;
		logic [15:0]       elapsed;
		bit                restart;
		bit                typed;
		cell_view_t        want;
	} stim_row_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [23:0]                    s_tdata = '0;
	logic [1:0]                     s_tuser = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [95:0]                    m_tdata;
	logic                           cfg_we = 1'b0;
	logic [sfs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [sfs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// register shadow
	logic [sfs_pkg::FRAME_W-1:0]   reg_start = '0;
	logic [sfs_pkg::COUNT_W-1:0]   reg_count = sfs_pkg::COUNT_W'(1);
	logic [sfs_pkg::TIME_BITS-1:0] reg_duration = '0;
	logic                          reg_loop = 1'b0;
	logic                          reg_reverse = 1'b0;
	logic [sfs_pkg::DIM_W-1:0]     reg_cols = sfs_pkg::DIM_W'(1);
	logic [sfs_pkg::DIM_W-1:0]     reg_rows = sfs_pkg::DIM_W'(1);

	// sequencer state
	logic [sfs_pkg::ACC_W-1:0]   acc_time = '0;
	logic [sfs_pkg::FRAME_W-1:0] frame_now = '0;
	logic                        playing_now = 1'b0;
	logic                        finished_now = 1'b0;
	logic                        clip_begun = 1'b0;

	cell_view_t pending_views[$];
	stim_row_t  plan[$];
	int         mismatches = 0;
	bit         calm = 1'b0;

	sprite_frame_sequencer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int unsigned cols_used();
		int unsigned c = reg_cols;
		if (c < 1) c = 1;
		if (c > sfs_pkg::MAX_COLUMNS) c = sfs_pkg::MAX_COLUMNS;
		return c;
	endfunction

	function automatic int unsigned rows_used();
		int unsigned r = reg_rows;
		if (r < 1) r = 1;
		if (r > sfs_pkg::MAX_ROWS) r = sfs_pkg::MAX_ROWS;
		return r;
	endfunction

	function automatic int unsigned fit_frame(int unsigned f);
		int unsigned cells = cols_used() * rows_used();
		if (cells > 4096) cells = 4096;
		return (f > cells - 1) ? cells - 1 : f;
	endfunction

	function automatic int unsigned clip_len();
		return (reg_count == 0) ? 1 : reg_count;
	endfunction

	function automatic int unsigned rewind_point();
		return reg_reverse ? reg_start + clip_len() - 1 : reg_start;
	endfunction

	function automatic void step_frame();
		int unsigned f = frame_now;
		int unsigned first = reg_start;
		int unsigned stop_at = reg_start + clip_len();
		if (reg_reverse) begin
			if (f <= first) begin
				if (reg_loop) begin
					f = stop_at - 1;
				end else begin
					f = first;
					playing_now = 1'b0;
					finished_now = 1'b1;
				end
			end else begin
				f = f - 1;
			end
		end else begin
			if (f + 1 >= stop_at) begin
				if (reg_loop) begin
					f = first;
				end else begin
					f = stop_at - 1;
					playing_now = 1'b0;
					finished_now = 1'b1;
				end
			end else begin
				f = f + 1;
			end
		end
		frame_now = sfs_pkg::FRAME_W'(fit_frame(f));
	endfunction

	function automatic cell_view_t advance_sequencer(sfs_pkg::op_t op, logic [15:0] elapsed,
			bit restart);
		int unsigned sum;
		int unsigned c;
		int unsigned r;
		int unsigned f;
		int unsigned col;
		int unsigned row;
		cell_view_t v;
		case (op)
			sfs_pkg::OP_TICK: begin
				if (playing_now && reg_duration != 0) begin
					sum = acc_time + elapsed;
					acc_time = (sum > ACC_LIMIT) ? sfs_pkg::ACC_W'(ACC_LIMIT) :
						sfs_pkg::ACC_W'(sum);
					while (acc_time >= reg_duration && playing_now) begin
						acc_time = acc_time - reg_duration;
						step_frame();
					end
				end
			end
			sfs_pkg::OP_PLAY: begin
				if (!clip_begun || restart) begin
					clip_begun = 1'b1;
					frame_now = sfs_pkg::FRAME_W'(fit_frame(rewind_point()));
					acc_time = '0;
				end
				playing_now = 1'b1;
				finished_now = 1'b0;
			end
			sfs_pkg::OP_STOP: begin
				playing_now = 1'b0;
			end
			default: begin
				frame_now = clip_begun ? sfs_pkg::FRAME_W'(fit_frame(rewind_point())) : '0;
				acc_time = '0;
				playing_now = 1'b0;
				finished_now = 1'b0;
			end
		endcase
		c = cols_used();
		r = rows_used();
		f = fit_frame(frame_now);
		col = f % c;
		row = f / c;
		v.frame = sfs_pkg::FRAME_W'(f);
		v.col = sfs_pkg::CELL_W'(col);
		v.row = sfs_pkg::CELL_W'(row);
		v.u_off = 16'((col * 65536) / c);
		v.v_off = 16'((row * 65536) / r);
		v.u_scl = 17'(65536 / c);
		v.v_scl = 17'(65536 / r);
		v.playing = playing_now;
		v.finished = finished_now;
		return v;
	endfunction

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	task automatic write_reg(sfs_pkg::cfg_idx_t sel, logic [15:0] value);
		s_tvalid = 1'b0;
		while (pending_views.size() != 0) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = sel;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		case (sel)
			sfs_pkg::CFG_START_FRAME:    reg_start = value[sfs_pkg::FRAME_W-1:0];
			sfs_pkg::CFG_FRAME_COUNT:    reg_count = value[sfs_pkg::COUNT_W-1:0];
			sfs_pkg::CFG_FRAME_DURATION: reg_duration = value;
			sfs_pkg::CFG_LOOP_ENABLE:    reg_loop = value[0];
			sfs_pkg::CFG_REVERSE:        reg_reverse = value[0];
			sfs_pkg::CFG_COLUMNS:        reg_cols = value[sfs_pkg::DIM_W-1:0];
			sfs_pkg::CFG_ROWS:           reg_rows = value[sfs_pkg::DIM_W-1:0];
			default: ;
		endcase
	endtask

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_item(sfs_pkg::op_t op, logic [15:0] elapsed, bit restart, bit typed,
			cell_view_t want);
		cell_view_t guess;
		if (!calm && $urandom_range(0, 99) < 17) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = op;
		s_tdata = {7'd0, restart, elapsed};
		do @(posedge clk); while (!s_tready);
		guess = advance_sequencer(op, elapsed, restart);
		pending_views.push_back(typed ? want : guess);
		@(negedge clk);
	endtask

	function automatic void add_item(sfs_pkg::op_t op, logic [15:0] elapsed, bit restart);
		stim_row_t s;
		s.kind = ROW_ITEM;
		s.sel = sfs_pkg::CFG_START_FRAME;
		s.value = '0;
		s.op = op;
		s.elapsed = elapsed;
		s.restart = restart;
		s.typed = 1'b0;
		s.want = '0;
		plan.push_back(s);
	endfunction

	function automatic void add_checked(sfs_pkg::op_t op, logic [15:0] elapsed, bit restart,
			cell_view_t want);
		add_item(op, elapsed, restart);
		plan[plan.size() - 1].typed = 1'b1;
		plan[plan.size() - 1].want = want;
	endfunction

	function automatic void add_cfg(sfs_pkg::cfg_idx_t sel, logic [15:0] value);
		stim_row_t s;
		s.kind = ROW_CFG;
		s.sel = sel;
		s.value = value;
		s.op = sfs_pkg::OP_TICK;
		s.elapsed = '0;
		s.restart = 1'b0;
		s.typed = 1'b0;
		s.want = '0;
		plan.push_back(s);
	endfunction

	task automatic pick_setting();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		write_reg(sfs_pkg::CFG_START_FRAME,
			(pick == 0) ? 16'($urandom_range(0, 4095)) : 16'($urandom_range(0, 40)));
		pick = $urandom_range(0, 19);
		if (pick == 0)
			write_reg(sfs_pkg::CFG_FRAME_COUNT, 16'd0);
		else if (pick == 1)
			write_reg(sfs_pkg::CFG_FRAME_COUNT, 16'($urandom_range(1, 8191)));
		else
			write_reg(sfs_pkg::CFG_FRAME_COUNT, 16'($urandom_range(1, 24)));
		pick = $urandom_range(0, 9);
		if (pick == 0)
			write_reg(sfs_pkg::CFG_FRAME_DURATION, 16'd0);
		else if (pick < 3)
			write_reg(sfs_pkg::CFG_FRAME_DURATION, 16'($urandom_range(1, 8)));
		else if (pick < 8)
			write_reg(sfs_pkg::CFG_FRAME_DURATION, 16'($urandom_range(9, 2000)));
		else if (pick == 8)
			write_reg(sfs_pkg::CFG_FRAME_DURATION, 16'($urandom_range(2000, 65535)));
		else
			write_reg(sfs_pkg::CFG_FRAME_DURATION, 16'd65535);
		write_reg(sfs_pkg::CFG_LOOP_ENABLE, 16'($urandom_range(0, 1)));
		write_reg(sfs_pkg::CFG_REVERSE, 16'($urandom_range(0, 1)));
		pick = $urandom_range(0, 9);
		write_reg(sfs_pkg::CFG_COLUMNS, (pick == 0) ? 16'($urandom_range(0, 127)) :
			(pick == 1) ? 16'd64 : 16'($urandom_range(1, 16)));
		pick = $urandom_range(0, 9);
		write_reg(sfs_pkg::CFG_ROWS, (pick == 0) ? 16'($urandom_range(0, 127)) :
			(pick == 1) ? 16'd64 : 16'($urandom_range(1, 16)));
	endtask

	task automatic random_item();
		int unsigned pick;
		int unsigned hi;
		logic [15:0] elapsed;
		sfs_pkg::op_t op;
		bit restart;
		pick = $urandom_range(0, 99);
		op = (pick < 58) ? sfs_pkg::OP_TICK : (pick < 78) ? sfs_pkg::OP_PLAY :
			(pick < 86) ? sfs_pkg::OP_STOP : sfs_pkg::OP_RESET;
		restart = (op == sfs_pkg::OP_PLAY) ? ($urandom_range(0, 3) == 0) :
			1'($urandom_range(0, 1));
		hi = 3 * reg_duration;
		if (hi > 65535) hi = 65535;
		if (reg_duration <= 8)
			elapsed = 16'($urandom_range(0, 64));
		else if ($urandom_range(0, 3) == 0)
			elapsed = 16'($urandom_range(0, 65535));
		else
			elapsed = 16'($urandom_range(0, hi));
		send_item(op, elapsed, restart, 1'b0, '0);
	endtask

	always @(negedge clk)
		m_tready = calm ? 1'b1 : ($urandom_range(0, 99) >= 17);

	always @(posedge clk) begin
		cell_view_t seen;
		cell_view_t want;
		if (arst_n && m_tvalid && m_tready) begin
			seen.frame = m_tdata[11:0];
			seen.col = m_tdata[17:12];
			seen.row = m_tdata[23:18];
			seen.u_off = m_tdata[39:24];
			seen.v_off = m_tdata[55:40];
			seen.u_scl = m_tdata[72:56];
			seen.v_scl = m_tdata[89:73];
			seen.playing = m_tdata[90];
			seen.finished = m_tdata[91];
			if (pending_views.size() == 0) begin
				report_mismatch("result with nothing pending", seen.frame, 0);
			end else begin
				want = pending_views.pop_front();
				if (seen.frame !== want.frame)
					report_mismatch("frame_index", seen.frame, want.frame);
				if (seen.col !== want.col)
					report_mismatch("cell_column", seen.col, want.col);
				if (seen.row !== want.row)
					report_mismatch("cell_row", seen.row, want.row);
				if (seen.u_off !== want.u_off)
					report_mismatch("u_offset", seen.u_off, want.u_off);
				if (seen.v_off !== want.v_off)
					report_mismatch("v_offset", seen.v_off, want.v_off);
				if (seen.u_scl !== want.u_scl)
					report_mismatch("u_scale", seen.u_scl, want.u_scl);
				if (seen.v_scl !== want.v_scl)
					report_mismatch("v_scale", seen.v_scl, want.v_scl);
				if (seen.playing !== want.playing)
					report_mismatch("is_playing", seen.playing, want.playing);
				if (seen.finished !== want.finished)
					report_mismatch("is_finished", seen.finished, want.finished);
			end
		end
	end

	initial begin
		#400_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// power-up view, reset before any play, first play
		add_checked(sfs_pkg::OP_TICK, 16'd0, 1'b0,
			cell_view_t'{12'd0, 6'd0, 6'd0, 16'd0, 16'd0, 17'd65536, 17'd65536, 1'b0, 1'b0});
		add_checked(sfs_pkg::OP_RESET, 16'd0, 1'b0,
			cell_view_t'{12'd0, 6'd0, 6'd0, 16'd0, 16'd0, 17'd65536, 17'd65536, 1'b0, 1'b0});
		add_checked(sfs_pkg::OP_PLAY, 16'd0, 1'b0,
			cell_view_t'{12'd0, 6'd0, 6'd0, 16'd0, 16'd0, 17'd65536, 17'd65536, 1'b1, 1'b0});
		add_cfg(sfs_pkg::CFG_COLUMNS, 16'd8);
		add_cfg(sfs_pkg::CFG_ROWS, 16'd8);
		add_cfg(sfs_pkg::CFG_START_FRAME, 16'd5);
		add_cfg(sfs_pkg::CFG_FRAME_COUNT, 16'd4);
		add_cfg(sfs_pkg::CFG_FRAME_DURATION, 16'd10);
		add_cfg(sfs_pkg::CFG_LOOP_ENABLE, 16'd0);
		add_item(sfs_pkg::OP_TICK, 16'd25, 1'b0);
		add_item(sfs_pkg::OP_PLAY, 16'd0, 1'b1);
		// runs to the clip end and finishes
		add_checked(sfs_pkg::OP_TICK, 16'hFFFF, 1'b0,
			cell_view_t'{12'd8, 6'd0, 6'd1, 16'd0, 16'd8192, 17'd8192, 17'd8192, 1'b0, 1'b1});
		add_item(sfs_pkg::OP_TICK, 16'd100, 1'b0);
		add_item(sfs_pkg::OP_PLAY, 16'd0, 1'b0);
		add_item(sfs_pkg::OP_TICK, 16'hFFFF, 1'b0);
		add_item(sfs_pkg::OP_PLAY, 16'd0, 1'b0);
		// accumulator saturates
		add_item(sfs_pkg::OP_TICK, 16'hFFFF, 1'b0);
		add_item(sfs_pkg::OP_TICK, 16'd0, 1'b0);
		add_cfg(sfs_pkg::CFG_LOOP_ENABLE, 16'd1);
		add_cfg(sfs_pkg::CFG_REVERSE, 16'd1);
		add_item(sfs_pkg::OP_PLAY, 16'd0, 1'b1);
		add_item(sfs_pkg::OP_TICK, 16'hFFFF, 1'b0);
		add_item(sfs_pkg::OP_STOP, 16'd0, 1'b0);
		add_item(sfs_pkg::OP_RESET, 16'd0, 1'b1);
		// zero count, oversize columns, zero rows, start past capacity
		add_cfg(sfs_pkg::CFG_FRAME_COUNT, 16'd0);
		add_cfg(sfs_pkg::CFG_START_FRAME, 16'd4095);
		add_cfg(sfs_pkg::CFG_COLUMNS, 16'd100);
		add_cfg(sfs_pkg::CFG_ROWS, 16'd0);
		add_item(sfs_pkg::OP_TICK, 16'd0, 1'b0);
		add_checked(sfs_pkg::OP_PLAY, 16'd0, 1'b1,
			cell_view_t'{12'd63, 6'd63, 6'd0, 16'd64512, 16'd0, 17'd1024, 17'd65536, 1'b1, 1'b0});
		add_item(sfs_pkg::OP_TICK, 16'hFFFF, 1'b0);
		add_cfg(sfs_pkg::CFG_COLUMNS, 16'd64);
		add_cfg(sfs_pkg::CFG_ROWS, 16'd64);
		add_cfg(sfs_pkg::CFG_START_FRAME, 16'd0);
		add_cfg(sfs_pkg::CFG_FRAME_COUNT, 16'd4096);
		add_cfg(sfs_pkg::CFG_FRAME_DURATION, 16'd65535);
		add_cfg(sfs_pkg::CFG_REVERSE, 16'd0);
		add_cfg(sfs_pkg::CFG_LOOP_ENABLE, 16'd0);
		add_item(sfs_pkg::OP_PLAY, 16'd0, 1'b1);
		add_item(sfs_pkg::OP_TICK, 16'hFFFF, 1'b0);
		add_item(sfs_pkg::OP_TICK, 16'hFFFF, 1'b0);
		add_cfg(sfs_pkg::CFG_FRAME_DURATION, 16'd0);
		add_item(sfs_pkg::OP_TICK, 16'd500, 1'b0);
		// stored frame now beyond the shrunken sheet
		add_cfg(sfs_pkg::CFG_COLUMNS, 16'd2);
		add_cfg(sfs_pkg::CFG_ROWS, 16'd1);
		add_checked(sfs_pkg::OP_TICK, 16'd0, 1'b0,
			cell_view_t'{12'd1, 6'd1, 6'd0, 16'd32768, 16'd0, 17'd32768, 17'd65536, 1'b1, 1'b0});
		add_item(sfs_pkg::OP_RESET, 16'd0, 1'b0);
		add_item(sfs_pkg::OP_STOP, 16'd0, 1'b1);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG)
				write_reg(plan[i].sel, plan[i].value);
			else
				send_item(plan[i].op, plan[i].elapsed, plan[i].restart, plan[i].typed,
					plan[i].want);
		end

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			pick_setting();
			calm = (p == 3);
			repeat (ITEMS_PER_PHASE) random_item();
		end
		calm = 1'b0;
		s_tvalid = 1'b0;

		while (pending_views.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
		if (mismatches == 0 && pending_views.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
